/* design/u8d_pkg.sv */
`default_nettype none

package u8d_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  // replacement character for broken sequences
  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // one input item: a raw byte and its end flag
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            was_replaced;
    logic            last_of_string;
  } result_t;

  // decoder status toward the handshake control
  typedef struct packed {
    logic has_result;
    logic in_sequence;
  } dec_status_t;

endpackage

`default_nettype wire

/* design/u8d_stream_if.sv */
`default_nettype none

// byte channel
interface u8d_byte_if;
  logic                        valid;
  logic                        ready;
  logic [u8d_pkg::BYTE_W-1:0]  data_byte;
  logic                        end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

// code point channel
interface u8d_cp_if;
  logic                      valid;
  logic                      ready;
  logic [u8d_pkg::CP_W-1:0]  code_point;
  logic                      was_replaced;
  logic                      last_of_string;

  modport source (
    output valid, output code_point, output was_replaced, output last_of_string, input ready
  );
  modport sink (
    input valid, input code_point, input was_replaced, input last_of_string, output ready
  );
endinterface

`default_nettype wire

/* design/u8d_in_stage.sv */
`default_nettype none

module u8d_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire u8d_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   s1_valid,
  output u8d_pkg::in_item_t      s1_item
);

  logic              valid_r;
  logic              valid_nxt;
  u8d_pkg::in_item_t item_r;
  logic              load;

  // take a new item when empty or when the held item moves on
  assign in_ready  = !valid_r || advance;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

/* design/u8d_decode.sv */
`default_nettype none

module u8d_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire u8d_pkg::in_item_t item,
  input  wire logic              advance,
  output u8d_pkg::dec_status_t   status,
  output u8d_pkg::result_t       result
);

  logic [1:0]               remain_r;
  logic [1:0]               remain_nxt;
  logic [u8d_pkg::CP_W-1:0] partial_r;
  logic [u8d_pkg::CP_W-1:0] partial_nxt;
  logic                     bad_r;
  logic                     bad_nxt;

  logic [7:0]               b;
  logic                     eos;
  logic                     cont_bad;
  logic [1:0]               remain_dec;
  logic [u8d_pkg::CP_W-1:0] partial_sh;

  assign b          = item.data_byte;
  assign eos        = item.end_of_string;
  assign cont_bad   = (b[7:6] != 2'b10);
  assign remain_dec = remain_r - 2'd1;
  assign partial_sh = {partial_r[u8d_pkg::CP_W-7:0], b[5:0]};

  // sequence decode and state update
  always_comb begin
    remain_nxt            = remain_r;
    partial_nxt           = partial_r;
    bad_nxt               = bad_r;
    status.has_result     = 1'b0;
    status.in_sequence    = (remain_r != 2'd0);
    result.code_point     = u8d_pkg::REPLACEMENT_CP;
    result.was_replaced   = 1'b1;
    result.last_of_string = eos;
    if (remain_r == 2'd0) begin
      priority if (b[7] == 1'b0) begin
        status.has_result   = 1'b1;
        result.code_point   = {{(u8d_pkg::CP_W-8){1'b0}}, b};
        result.was_replaced = 1'b0;
      end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
        if (eos) begin
          // lead byte cut short by the end of the string
          status.has_result = 1'b1;
          remain_nxt        = 2'd0;
          partial_nxt       = '0;
          bad_nxt           = 1'b0;
        end else begin
          bad_nxt = 1'b0;
          priority if (b[7:5] == 3'b110) begin
            remain_nxt  = 2'd1;
            partial_nxt = {{(u8d_pkg::CP_W-5){1'b0}}, b[4:0]};
          end else if (b[7:4] == 4'b1110) begin
            remain_nxt  = 2'd2;
            partial_nxt = {{(u8d_pkg::CP_W-4){1'b0}}, b[3:0]};
          end else begin
            remain_nxt  = 2'd3;
            partial_nxt = {{(u8d_pkg::CP_W-3){1'b0}}, b[2:0]};
          end
        end
      end else begin
        // stray continuation or invalid lead
        status.has_result = 1'b1;
      end
    end else begin
      if (remain_dec == 2'd0) begin
        // sequence complete
        status.has_result = 1'b1;
        if (!(bad_r || cont_bad)) begin
          result.code_point   = partial_sh;
          result.was_replaced = 1'b0;
        end
        remain_nxt  = 2'd0;
        partial_nxt = '0;
        bad_nxt     = 1'b0;
      end else if (eos) begin
        // continuation cut short by the end of the string
        status.has_result = 1'b1;
        remain_nxt        = 2'd0;
        partial_nxt       = '0;
        bad_nxt           = 1'b0;
      end else begin
        remain_nxt  = remain_dec;
        partial_nxt = partial_sh;
        bad_nxt     = bad_r || cont_bad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r  <= 2'd0;
      partial_r <= '0;
      bad_r     <= 1'b0;
    end else if (advance) begin
      remain_r  <= remain_nxt;
      partial_r <= partial_nxt;
      bad_r     <= bad_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/u8d_out_stage.sv */
`default_nettype none

module u8d_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire u8d_pkg::result_t result,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output u8d_pkg::result_t      out_item
);

  logic             valid_r;
  logic             valid_nxt;
  u8d_pkg::result_t item_r;

  // register is free when empty or being drained this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

/* design/utf8_stream_decoder_top.sv */
// utf8_stream_decoder_top: streaming UTF-8 to code point decoder.
// in_stream carries one byte per item with end_of_string on the final byte
// of a string; out_stream carries one code point per completed sequence,
// with was_replaced set when 0xFFFD stands for a broken sequence and
// last_of_string copied from the byte that closed it.
// Lead and inner bytes of multi-byte sequences produce no item; a string
// ending on one of them yields a replacement. Each byte passes the input
// register, then is decoded into the result register. Throughput: one byte
// per cycle unless an item finds the result register full, set by the
// single decode step between the input register and the result register.
// Reset (rst_n low, synchronous) empties both registers and clears the
// sequence state. When the receiver stalls, a finished item waits in the
// result register; bytes that produce no item keep flowing, and a byte that
// produces an item waits in the input register, which holds in_stream.ready
// low only once both registers are occupied.
`default_nettype none

module utf8_stream_decoder_top (
  input  wire logic clk,
  input  wire logic rst_n,
  u8d_byte_if.sink  in_stream,
  u8d_cp_if.source  out_stream
);

  u8d_pkg::in_item_t    in_item;
  u8d_pkg::in_item_t    s1_item;
  logic                 s1_valid;
  logic                 advance;
  logic                 out_free;
  logic                 out_load;
  u8d_pkg::dec_status_t status;
  u8d_pkg::result_t     result;
  u8d_pkg::result_t     out_item;

  assign in_item.data_byte     = in_stream.data_byte;
  assign in_item.end_of_string = in_stream.end_of_string;

  u8d_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_stream.valid),
    .in_ready (in_stream.ready),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  u8d_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (s1_item),
    .advance (advance),
    .status  (status),
    .result  (result)
  );

  // held byte moves on unless its item finds the result register full
  assign advance  = s1_valid && (!status.has_result || out_free);
  assign out_load = advance && status.has_result;

  u8d_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .result    (result),
    .free      (out_free),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .out_item  (out_item)
  );

  assign out_stream.code_point     = out_item.code_point;
  assign out_stream.was_replaced   = out_item.was_replaced;
  assign out_stream.last_of_string = out_item.last_of_string;

  // input backs up only when both stages hold a waiting item
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stream.ready |-> (s1_valid && out_stream.valid && !out_stream.ready))
    else $error("input stalled without a blocked result");

  // every emitted item closes the sequence
  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !status.in_sequence)
    else $error("sequence state left open after an item");

  // a replaced item always carries the replacement character
  a_replaced_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && out_stream.was_replaced) |->
      (out_stream.code_point == u8d_pkg::REPLACEMENT_CP))
    else $error("replaced item with wrong code point");

endmodule

`default_nettype wire

/* verif/utf8_stream_decoder_top_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_decoder_top_tb;

  localparam int unsigned RANDOM_BYTES   = 600;
  localparam int unsigned MAX_GAP        = 11;
  localparam int unsigned HOLD_OFF_AFTER = 80;
  localparam int unsigned HOLD_OFF_LEN   = 300;
  localparam int unsigned DRAIN_LIMIT    = 5000;
  localparam int unsigned TAIL_CYCLES    = 8;

  // well-formed sequence lengths and broken shapes of the random part
  typedef enum int {SEQ_GOOD, SEQ_BAD_LEAD, SEQ_BAD_CONT, SEQ_CUT_SHORT, SEQ_NOISE} seq_kind_t;

  // decoder predictor and queue of code points still owed by the block
  class code_point_tracker;
    bit [1:0]               cont_left;
    bit [u8d_pkg::CP_W-1:0] gathered;
    bit                     cont_broken;
    u8d_pkg::result_t       owed_cps[$];
    int unsigned            n_bytes;
    int unsigned            n_results;
    int unsigned            n_replaced;
    int unsigned            n_errors;

    function new();
      cont_left   = '0;
      gathered    = '0;
      cont_broken = 1'b0;
    endfunction

    function void owe(bit [u8d_pkg::CP_W-1:0] cp, bit replaced, bit last);
      u8d_pkg::result_t r;
      r.code_point     = cp;
      r.was_replaced   = replaced;
      r.last_of_string = last;
      owed_cps = {owed_cps, r};
    endfunction

    function void clear_sequence();
      cont_left   = '0;
      gathered    = '0;
      cont_broken = 1'b0;
    endfunction

    // one accepted byte: advance the decoder and note the code point it closes
    function void note_byte(bit [u8d_pkg::BYTE_W-1:0] b, bit eos);
      bit [1:0]               follow;
      bit [u8d_pkg::CP_W-1:0] lead_bits;
      n_bytes++;
      if (cont_left == 2'd0) begin
        if (b[7] == 1'b0) begin
          owe(u8d_pkg::CP_W'(b), 1'b0, eos);
          return;
        end else if (b[7:5] == 3'b110) begin
          follow    = 2'd1;
          lead_bits = u8d_pkg::CP_W'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          follow    = 2'd2;
          lead_bits = u8d_pkg::CP_W'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          follow    = 2'd3;
          lead_bits = u8d_pkg::CP_W'(b[2:0]);
        end else begin
          owe(u8d_pkg::REPLACEMENT_CP, 1'b1, eos);
          return;
        end
        // string ends on a multi-byte lead
        if (eos) begin
          clear_sequence();
          owe(u8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1);
          return;
        end
        cont_left   = follow;
        gathered    = lead_bits;
        cont_broken = 1'b0;
        return;
      end
      // continuation bytes are always taken in
      if (b[7:6] != 2'b10) cont_broken = 1'b1;
      gathered  = {gathered[u8d_pkg::CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        if (cont_broken) owe(u8d_pkg::REPLACEMENT_CP, 1'b1, eos);
        else owe(gathered, 1'b0, eos);
        clear_sequence();
      end else if (eos) begin
        clear_sequence();
        owe(u8d_pkg::REPLACEMENT_CP, 1'b1, 1'b1);
      end
    endfunction

    // one accepted code point: compare with the oldest one owed
    function void check_code_point(bit [u8d_pkg::CP_W-1:0] cp, bit replaced, bit last);
      u8d_pkg::result_t want;
      if (owed_cps.size() == 0) begin
        $error("unexpected code point %h (replaced %0b, last %0b)", cp, replaced, last);
        n_errors++;
        return;
      end
      want = owed_cps.pop_front();
      n_results++;
      if (replaced) n_replaced++;
      if (cp != want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, cp);
        n_errors++;
      end
      if (replaced != want.was_replaced) begin
        $error("was_replaced: expected %0b, got %0b", want.was_replaced, replaced);
        n_errors++;
      end
      if (last != want.last_of_string) begin
        $error("last_of_string: expected %0b, got %0b", want.last_of_string, last);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  u8d_byte_if byte_ch ();
  u8d_cp_if   cp_ch ();

  utf8_stream_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (byte_ch),
    .out_stream (cp_ch)
  );

  code_point_tracker tracker = new();
  int unsigned       n_strings;
  bit                tx_burst;
  bit                rx_burst;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // handshake monitor, values seen just before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cp_ch.valid && cp_ch.ready)
        tracker.check_code_point(cp_ch.code_point, cp_ch.was_replaced, cp_ch.last_of_string);
      if (byte_ch.valid && byte_ch.ready)
        tracker.note_byte(byte_ch.data_byte, byte_ch.end_of_string);
    end
  end

  // offer one byte after a random gap and wait until it is taken
  task automatic send_byte(bit [u8d_pkg::BYTE_W-1:0] b, bit eos);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_string <= eos;
    @(posedge clk);
    while (!(byte_ch.valid && byte_ch.ready)) @(posedge clk);
  endtask

  function automatic bit [7:0] lead_byte(int unsigned len);
    bit [7:0] r;
    r = 8'($urandom);
    case (len)
      1: begin
        return {1'b0, r[6:0]};
      end
      2: begin
        return {3'b110, r[4:0]};
      end
      3: begin
        return {4'b1110, r[3:0]};
      end
      default: begin
        return {5'b11110, r[2:0]};
      end
    endcase
  endfunction

  function automatic bit [7:0] cont_byte();
    bit [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  // one string of random sequences, mostly well formed, end flag on its last byte
  task automatic send_random_string(inout int unsigned sent);
    bit [7:0]    str_bytes[$];
    int unsigned n_seq;
    int unsigned len;
    int unsigned pick;
    int unsigned bad_pos;
    bit [7:0]    junk;
    seq_kind_t   kind;
    bit          cut;
    n_seq = $urandom_range(1, 6);
    cut   = 1'b0;
    for (int unsigned s = 0; s < n_seq && !cut; s++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) kind = SEQ_GOOD;
      else if (pick < 86) kind = SEQ_BAD_LEAD;
      else if (pick < 92) kind = SEQ_BAD_CONT;
      else if (pick < 96) kind = SEQ_CUT_SHORT;
      else kind = SEQ_NOISE;
      case (kind)
        SEQ_GOOD: begin
          len = $urandom_range(1, 4);
          str_bytes = {str_bytes, lead_byte(len)};
          for (int unsigned i = 1; i < len; i++) str_bytes = {str_bytes, cont_byte()};
        end
        SEQ_BAD_LEAD: begin
          junk = 8'($urandom);
          if ($urandom_range(0, 1) == 0) str_bytes = {str_bytes, {2'b10, junk[5:0]}};
          else str_bytes = {str_bytes, {5'b11111, junk[2:0]}};
        end
        SEQ_BAD_CONT: begin
          len     = $urandom_range(2, 4);
          bad_pos = $urandom_range(1, len - 1);
          str_bytes = {str_bytes, lead_byte(len)};
          for (int unsigned i = 1; i < len; i++) begin
            if (i == bad_pos) begin
              junk = 8'($urandom);
              if (junk[7:6] == 2'b10) junk[6] = 1'b1;
              str_bytes = {str_bytes, junk};
            end else begin
              str_bytes = {str_bytes, cont_byte()};
            end
          end
        end
        SEQ_CUT_SHORT: begin
          len = $urandom_range(2, 4);
          str_bytes = {str_bytes, lead_byte(len)};
          repeat ($urandom_range(0, len - 2)) str_bytes = {str_bytes, cont_byte()};
          cut = 1'b1;
        end
        default: begin
          str_bytes = {str_bytes, 8'($urandom)};
        end
      endcase
    end
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
    sent += str_bytes.size();
    n_strings++;
  endtask

  // receiver: random stalls per item plus one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          held;
    taken = 0;
    held  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (!held && taken >= HOLD_OFF_AFTER) begin
        gap  = HOLD_OFF_LEN;
        held = 1'b1;
      end
      if (gap > 0) begin
        cp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(cp_ch.valid && cp_ch.ready)) @(posedge clk);
      taken++;
    end
  end

  // watchdog
  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  // main sequence: reset, directed bytes, random strings, drain
  initial begin
    int unsigned sent;
    int unsigned waited;
    sent      = 0;
    n_strings = 0;
    tx_burst  = 1'b0;
    rx_burst  = 1'b0;
    rst_n                 <= 1'b0;
    byte_ch.valid         <= 1'b0;
    byte_ch.data_byte     <= '0;
    byte_ch.end_of_string <= 1'b0;
    cp_ch.ready           <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascii extremes, the last one closing a string
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // smallest and largest two-byte forms
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    // decoded 0xfffd, not a replacement
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBD, 1'b0);
    // four-byte forms up to the widest value
    send_byte(8'hF0, 1'b0);
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
    // invalid leads: stray continuation and 11111xxx
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
    // continuation without the 10 prefix
    send_byte(8'hC2, 1'b0);
    send_byte(8'h41, 1'b0);
    // string ends on a lead, then inside a sequence
    send_byte(8'hE2, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    n_strings += 5;

    while (sent < RANDOM_BYTES) send_random_string(sent);
    byte_ch.valid <= 1'b0;

    waited = 0;
    while (tracker.owed_cps.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.owed_cps.size() > 0) begin
      $error("%0d code points never arrived", tracker.owed_cps.size());
      tracker.n_errors++;
    end

    $display("decoded %0d bytes in %0d strings into %0d code points, %0d of them replacements",
             tracker.n_bytes, n_strings, tracker.n_results, tracker.n_replaced);
    $display("random stalls on both sides and one long output hold-off of %0d cycles",
             HOLD_OFF_LEN);
    if (tracker.n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/u8d_pkg.sv
design/u8d_stream_if.sv
design/u8d_in_stage.sv
design/u8d_decode.sv
design/u8d_out_stage.sv
design/utf8_stream_decoder_top.sv
verif/utf8_stream_decoder_top_tb.sv
